// ===== hdl/pdd_pkg.sv =====
package pdd_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  // fractional bits of the coordinate format; the datapath works on raw integers
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 32;
  localparam int ACC_W          = 63;
  localparam int COUNT_W        = 11;
  localparam int DIFF_W         = 33;
  localparam int SQ_W           = 67;
  localparam int ROOT_W         = 34;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD,
    ST_WAIT,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_START,
    ST_ROOT,
    ST_ACC,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic store;
    logic clear;
    logic rd;
    logic diff;
    logic sq;
    logic sum;
    logic root_start;
    logic acc;
    logic pair_next;
    logic div_start;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic last_pair;
    logic div_done;
  } sts_t;

endpackage

// ===== hdl/pdd_datapath.sv =====
module pdd_datapath #(
  parameter int MAX_POINTS = pdd_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pdd_pkg::cmd_t                cmd,
  output pdd_pkg::sts_t                sts,
  input  logic [4*pdd_pkg::COORD_W-1:0] pt_in,
  output logic [pdd_pkg::ACC_W-1:0]    total_error,
  output logic [pdd_pkg::ACC_W-1:0]    average_error,
  output logic [pdd_pkg::COUNT_W-1:0]  point_count,
  output logic                         overflow
);
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int CWS = pdd_pkg::COORD_W;
  localparam logic [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

  logic [4*CWS-1:0] mem [MAX_POINTS];
  logic [4*CWS-1:0] pv_r, pw_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] v_r, w_r;
  logic drop_r, sat_r;
  logic [63:0] acc_r;
  logic [pdd_pkg::DIFF_W-1:0] d_r [4];
  logic [65:0] sq_r [4];
  logic [pdd_pkg::SQ_W-1:0] s1_r, s2_r;
  logic [pdd_pkg::SQ_W-1:0] rem1_r, rem2_r;
  logic [pdd_pkg::ROOT_W-1:0] r1_r, r2_r;
  logic [5:0] bit_r;
  logic rbusy_r;
  logic [63:0] q_r, dn_r;
  logic [CW:0] dr_r;
  logic [6:0] dbit_r;

  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < MAXP)) mem[cnt_r[AW-1:0]] <= pt_in;
    if (cmd.rd) begin
      pv_r <= mem[v_r];
      pw_r <= mem[w_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0; drop_r <= 1'b0; sat_r <= 1'b0; acc_r <= '0;
      v_r <= '0; w_r <= '0;
    end else begin
      if (cmd.store) begin
        if (cnt_r < MAXP) cnt_r <= cnt_r + 1'b1;
        else drop_r <= 1'b1;
      end
      if (cmd.acc) begin
        logic [63:0] t;
        t = {30'b0, (r2_r > r1_r) ? (r2_r - r1_r) : (r1_r - r2_r)};
        if (acc_r > ACC_MAX - t) begin
          acc_r <= ACC_MAX; sat_r <= 1'b1;
        end else acc_r <= acc_r + t;
      end
      if (cmd.pair_next) begin
        if ({1'b0, w_r} == cnt_r - 1'b1) begin
          w_r <= '0; v_r <= v_r + 1'b1;
        end else w_r <= w_r + 1'b1;
      end
    end
  end

  assign sts.last_pair = ({1'b0, w_r} == cnt_r - 1'b1) && ({1'b0, v_r} == cnt_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [pdd_pkg::DIFF_W-1:0] a, b, d;
        a = {pw_r[k*CWS+CWS-1], pw_r[k*CWS +: CWS]};
        b = {pv_r[k*CWS+CWS-1], pv_r[k*CWS +: CWS]};
        d = a - b;
        d_r[k] <= d[pdd_pkg::DIFF_W-1] ? -d : d;
      end
    end
    if (cmd.sq)
      for (int k = 0; k < 4; k++) sq_r[k] <= d_r[k] * d_r[k];
    if (cmd.sum) begin
      s1_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
      s2_r <= {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
    end
  end

  // restoring integer square root, one result bit per cycle for both maps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbusy_r <= 1'b0; bit_r <= '0;
    end else if (cmd.root_start) begin
      rbusy_r <= 1'b1; bit_r <= 6'd33;
      rem1_r <= s1_r; rem2_r <= s2_r; r1_r <= '0; r2_r <= '0;
    end else if (rbusy_r) begin
      logic [pdd_pkg::SQ_W+1:0] c1, c2;
      c1 = ({35'b0, r1_r} << (bit_r + 7'd1)) + (69'd1 << (2 * bit_r));
      c2 = ({35'b0, r2_r} << (bit_r + 7'd1)) + (69'd1 << (2 * bit_r));
      if (c1 <= {2'b0, rem1_r}) begin
        rem1_r <= rem1_r - c1[pdd_pkg::SQ_W-1:0];
        r1_r <= r1_r | (pdd_pkg::ROOT_W'(1) << bit_r);
      end
      if (c2 <= {2'b0, rem2_r}) begin
        rem2_r <= rem2_r - c2[pdd_pkg::SQ_W-1:0];
        r2_r <= r2_r | (pdd_pkg::ROOT_W'(1) << bit_r);
      end
      if (bit_r == 6'd0) rbusy_r <= 1'b0;
      else bit_r <= bit_r - 1'b1;
    end
  end
  assign sts.root_done = !rbusy_r && !cmd.root_start;

  // restoring division acc / count, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dn_r <= acc_r; q_r <= '0; dr_r <= '0; dbit_r <= 7'd64;
    end else if (cmd.div_step && dbit_r != 0) begin
      logic [CW+1:0] t;
      t = {dr_r, dn_r[63]};
      dn_r <= dn_r << 1;
      if (t >= {2'b0, cnt_r}) begin
        dr_r <= (CW+1)'(t - {2'b0, cnt_r}); q_r <= {q_r[62:0], 1'b1};
      end else begin
        dr_r <= t[CW:0]; q_r <= {q_r[62:0], 1'b0};
      end
      dbit_r <= dbit_r - 1'b1;
    end
  end
  assign sts.div_done = (dbit_r == 0) && !cmd.div_start;

  assign total_error   = acc_r[62:0];
  assign average_error = (cnt_r == 0) ? '0 : q_r[62:0];
  assign point_count   = pdd_pkg::COUNT_W'(cnt_r);
  assign overflow      = sat_r | drop_r;
endmodule

// ===== hdl/pdd_ctrl.sv =====
module pdd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_last,
  input  logic          out_tready,
  output logic          in_tready,
  output logic          out_tvalid,
  input  pdd_pkg::sts_t sts,
  output pdd_pkg::cmd_t cmd
);
  pdd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pdd_pkg::ST_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      pdd_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_fire) begin
          cmd.store = 1'b1;
          if (in_last) state_nxt = pdd_pkg::ST_RD;
        end
      end
      pdd_pkg::ST_RD:   begin cmd.rd = 1'b1; state_nxt = pdd_pkg::ST_WAIT; end
      pdd_pkg::ST_WAIT: state_nxt = pdd_pkg::ST_DIFF;
      pdd_pkg::ST_DIFF: begin cmd.diff = 1'b1; state_nxt = pdd_pkg::ST_SQ; end
      pdd_pkg::ST_SQ:   begin cmd.sq = 1'b1; state_nxt = pdd_pkg::ST_SUM; end
      pdd_pkg::ST_SUM: begin
        cmd.sum = 1'b1; state_nxt = pdd_pkg::ST_START;
      end
      // root loads the sums registered in the previous cycle
      pdd_pkg::ST_START: begin
        cmd.root_start = 1'b1; state_nxt = pdd_pkg::ST_ROOT;
      end
      pdd_pkg::ST_ROOT: begin
        if (sts.root_done) state_nxt = pdd_pkg::ST_ACC;
      end
      pdd_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last_pair) begin
          state_nxt = pdd_pkg::ST_DSTART;
        end else begin
          cmd.pair_next = 1'b1; state_nxt = pdd_pkg::ST_RD;
        end
      end
      // division takes the accumulator after the last term is in
      pdd_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1; state_nxt = pdd_pkg::ST_DIV;
      end
      pdd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = pdd_pkg::ST_OUT;
      end
      pdd_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.clear = 1'b1; state_nxt = pdd_pkg::ST_LOAD;
        end
      end
      default: state_nxt = pdd_pkg::ST_LOAD;
    endcase
  end
endmodule

// ===== hdl/pairwise_distance_discrepancy.sv =====
// Pairwise distance discrepancy. Points load one per transfer into the point
// memory; the transfer with tlast starts the compute phase, during which no
// input is taken. Each ordered pair goes through memory read, diff, square,
// sum, then a 34-step bit-serial square root for both maps, then the
// accumulate; after the last pair a bit-serial division of the total by the
// point count forms the average.
module pairwise_distance_discrepancy #(
  parameter int MAX_POINTS = pdd_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // x_first, y_first, x_second, y_second
  input  logic [127:0]  in_tdata,
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  // total_error, average_error, point_count, overflow, zero pad
  output logic [143:0]  out_tdata
);
  pdd_pkg::cmd_t cmd;
  pdd_pkg::sts_t sts;
  logic [62:0] tot, avg;
  logic [10:0] cnt;
  logic ovf;

  pdd_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .in_last(in_tlast),
    .out_tready, .in_tready, .out_tvalid, .sts, .cmd
  );

  pdd_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .pt_in(in_tdata),
    .total_error(tot), .average_error(avg), .point_count(cnt), .overflow(ovf)
  );

  assign out_tdata = {6'b0, ovf, cnt, avg, tot};
endmodule

// ===== hdl/pdd_checker.sv =====
module pdd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[136:126] != 11'd0)
    else $error("result with zero count");
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready)
    else $error("not ready after result");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("not ready within a batch");
endmodule

bind pairwise_distance_discrepancy pdd_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast, .out_tvalid, .out_tready, .out_tdata
);

// ===== test/pairwise_distance_discrepancy_tb.sv =====
`timescale 1ns / 100ps

module pairwise_distance_discrepancy_tb;

  localparam logic [63:0] ACC_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [pdd_pkg::COORD_W-1:0] xf, yf, xs, ys;
    bit last;
    bit hold;   // wait for all totals before presenting this point
  } point_t;

  typedef struct {
    logic [pdd_pkg::ACC_W-1:0]   total;
    logic [pdd_pkg::ACC_W-1:0]   avg;
    logic [pdd_pkg::COUNT_W-1:0] count;
    logic                        ovf;
  } batch_total_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;

  point_t       pending_pts[$];
  point_t       batch_pts[$];
  batch_total_t totals_q[$];
  int           errors = 0;
  int           batches_seen = 0;
  int           points_sent = 0;
  int           gap = 0;
  int           burst = 0;
  int           stall = 0;

  pairwise_distance_discrepancy dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // floor(sqrt(dx^2 + dy^2)) on raw Q16.16 coordinates
  function automatic logic [pdd_pkg::ROOT_W-1:0] dist_floor(logic signed [31:0] ax, ay, bx, by);
    logic signed [32:0] dx, dy;
    logic [32:0] mx, my;
    logic [66:0] s;
    logic [67:0] c2;
    logic [pdd_pkg::ROOT_W-1:0] r, c;
    dx = {ax[31], ax} - {bx[31], bx};
    dy = {ay[31], ay} - {by[31], by};
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
    s = {34'b0, mx} * {34'b0, mx} + {34'b0, my} * {34'b0, my};
    r = '0;
    for (int b = pdd_pkg::ROOT_W - 1; b >= 0; b--) begin
      c = r | (34'd1 << b);
      c2 = {34'b0, c} * {34'b0, c};
      if (c2 <= {1'b0, s}) r = c;
    end
    return r;
  endfunction

  task automatic load_point(point_t p);
    logic [63:0] acc;
    logic [pdd_pkg::ROOT_W-1:0] d1, d2;
    logic [63:0] term;
    bit sat;
    batch_total_t t;
    int n;
    batch_pts.insert(batch_pts.size(), p);
    points_sent++;
    if (!p.last) return;
    n = batch_pts.size();
    acc = 0;
    sat = 0;
    foreach (batch_pts[v]) begin
      foreach (batch_pts[w]) begin
        d1 = dist_floor(batch_pts[w].xf, batch_pts[w].yf, batch_pts[v].xf, batch_pts[v].yf);
        d2 = dist_floor(batch_pts[w].xs, batch_pts[w].ys, batch_pts[v].xs, batch_pts[v].ys);
        term = (d2 > d1) ? 64'(d2 - d1) : 64'(d1 - d2);
        if (acc > ACC_CEIL - term) begin
          acc = ACC_CEIL;
          sat = 1;
        end else begin
          acc = acc + term;
        end
      end
    end
    t.total = acc[pdd_pkg::ACC_W-1:0];
    t.avg = 63'(acc / n);
    t.count = pdd_pkg::COUNT_W'(n);
    t.ovf = sat;
    totals_q.insert(totals_q.size(), t);
    batch_pts.delete();
  endtask

  // sender
  always @(posedge clk) begin
    bit nv;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        load_point(pending_pts.pop_front());
        nv = 0;
      end
      if (!nv) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_pts.size() > 0 && !(pending_pts[0].hold && totals_q.size() > 0)) begin
          in_tdata <= {pending_pts[0].ys, pending_pts[0].xs, pending_pts[0].yf, pending_pts[0].xf};
          in_tlast <= pending_pts[0].last;
          nv = 1;
          if (burst > 0) begin
            burst--;
          end else begin
            burst = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // receiver
  always @(posedge clk) begin
    batch_total_t e;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        batches_seen++;
        if (totals_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = totals_q.pop_front();
          if (out_tdata[62:0] !== e.total) begin
            $error("total_error exp %0d got %0d", e.total, out_tdata[62:0]);
            errors++;
          end
          if (out_tdata[125:63] !== e.avg) begin
            $error("average_error exp %0d got %0d", e.avg, out_tdata[125:63]);
            errors++;
          end
          if (out_tdata[136:126] !== e.count) begin
            $error("point_count exp %0d got %0d", e.count, out_tdata[136:126]);
            errors++;
          end
          if (out_tdata[137] !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, out_tdata[137]);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if ($urandom_range(0, 3) == 0) stall = $urandom_range(1, 20);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_point(logic [31:0] xf, yf, xs, ys, bit last, bit hold = 0);
    point_t p;
    p.xf = xf; p.yf = yf; p.xs = xs; p.ys = ys; p.last = last; p.hold = hold;
    pending_pts.insert(pending_pts.size(), p);
  endtask

  initial begin
    int n;
    int queued;
    // directed: single point, extremes, zero distance, identical maps
    add_point(32'h0, 32'h0, 32'h0, 32'h0, 1);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 0);
    add_point(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    add_point(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 0);
    add_point(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 1);
    add_point(32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 0, 1);
    add_point(32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    add_point(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 1);
    queued = 11;
    while (queued < 1250) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        add_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == n - 1,
                  i == 0 && $urandom_range(0, 40) == 0);
      queued += n;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    wait (pending_pts.size() == 0 && !in_tvalid);
    wait (totals_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d points sent in %0d batches of 1 to 20 points, full-range coordinates",
             points_sent, batches_seen);
    if (errors == 0)
      $display("pairwise_distance_discrepancy test passed");
    else
      $display("pairwise_distance_discrepancy test failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("pairwise_distance_discrepancy test failed");
    $finish;
  end

endmodule
